>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the suffix repetition stop detector.
// Needs no other file; the asserting module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRSD_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SRSD_ASSERT(lbl, prop, msg) `SRSD_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)
`else
`define SRSD_ASSERT_CR(lbl, clk, rstn, prop, msg)
`define SRSD_ASSERT(lbl, prop, msg)
`endif
`endif

>>> rtl/srsd_pkg.sv
// Package of the suffix repetition stop detector: sizes, types and codes.
// Used by the top level and the testbench; depends on nothing.
package srsd_pkg;

  localparam int WINDOW   = 50;
  localparam int AW       = $clog2(WINDOW);
  localparam int CW       = $clog2(WINDOW + 1);
  localparam int CMP_W    = CW + 1;
  localparam int LANES    = WINDOW / 2;
  localparam int BYTE_W   = 8;
  localparam int MP_W     = 5;
  localparam int TH_W     = 4;
  localparam int RUN_W    = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 1;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [MP_W-1:0]      mp_t;
  typedef logic [TH_W-1:0]      th_t;
  typedef logic [RUN_W-1:0]     run_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [LANES-1:0]     lane_vec_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam mp_t  MIN_PATTERN_RST    = mp_t'(5);
  localparam th_t  STOP_THRESHOLD_RST = th_t'(2);
  localparam run_t RUN_MAX            = '1;

  localparam reg_idx_t REG_MIN_PATTERN    = reg_idx_t'(0);
  localparam reg_idx_t REG_STOP_THRESHOLD = reg_idx_t'(1);

  localparam logic FUNC_APPEND  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

>>> rtl/srsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the text window of the detector.
module srsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/suffix_repetition_stop_detector_top.sv
// Top level of the suffix repetition stop detector: window sweep and run counter.
// Depends on srsd_pkg, srsd_ram and assert_macros.svh.
//
//   channel | direction | handshake             | beat
//   in      | input     | in_valid_i/in_stall_o | func, text_byte, piece_end
//   out     | output    | out_valid_o/out_stall_i | repetitive, stop, run_length
//   cfg     | input     | APB psel/penable      | min_pattern, stop_threshold
//
// An append beat without a piece end, and a restart beat, leave the block idle.
// A checked beat on a window of at least 2*min_pattern bytes sweeps fill_count - 1
// stored bytes, one RAM read per cycle; its result is loaded in the done state, and
// the next beat is accepted once the block has returned to idle.
// A match ends the sweep early; a shorter window skips it and is not repetitive.
// A stalled result holds the block in its done state until the output register frees.
// Reset clears fill and run counts and state, not the result data, history or RAM.
`include "assert_macros.svh"

module suffix_repetition_stop_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_func_i,
  input  logic [7:0]                    in_text_byte_i,
  input  logic                          in_piece_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_repetitive_o,
  output logic                          out_stop_o,
  output logic [3:0]                    out_run_length_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [srsd_pkg::PDATA_W-1:0]  pwdata,
  output logic [srsd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  srsd_pkg::state_e    state_q, state_d;
  srsd_pkg::mp_t       mp_q;
  srsd_pkg::th_t       th_q;
  srsd_pkg::cnt_t      fill_q, fill_d, fill_inc;
  srsd_pkg::addr_t     wp_q, wp_d, wp_inc;
  srsd_pkg::addr_t     rp_q, rp_d, rp_inc, oldest;
  srsd_pkg::cnt_t      issue_q, issue_d;
  srsd_pkg::cnt_t      scan_len_q, scan_len_d;
  logic                rd_vld_q, rd_vld_d;
  srsd_pkg::lane_vec_t dvec_q, dvec_d, dvec_next;
  srsd_pkg::lane_vec_t lane_eq, lane_mask, lane_first;
  logic                match_q, match_d;
  srsd_pkg::run_t      run_q, run_d;
  logic                out_valid_q, out_valid_d;
  logic                out_rep_q, out_stop_q;
  srsd_pkg::run_t      out_run_q;
  logic                out_load;
  srsd_pkg::byte_t     hist_q [srsd_pkg::LANES];
  srsd_pkg::byte_t     rd_data;
  logic                ram_we, ram_re;
  logic                in_acc, cfg_we, issuing, len_ok;
  srsd_pkg::mp_t       m_eff;
  srsd_pkg::cmp_t      two_m, wrap_sum;
  srsd_pkg::reg_idx_t  reg_idx;

  assign in_stall_o = (state_q != srsd_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pready     = 1'b1;
  assign reg_idx    = paddr[srsd_pkg::PADDR_W-1:2];
  assign cfg_we     = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      srsd_pkg::REG_MIN_PATTERN:    prdata = srsd_pkg::PDATA_W'(mp_q);
      srsd_pkg::REG_STOP_THRESHOLD: prdata = srsd_pkg::PDATA_W'(th_q);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q <= srsd_pkg::MIN_PATTERN_RST;
      th_q <= srsd_pkg::STOP_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        srsd_pkg::REG_MIN_PATTERN:    mp_q <= pwdata[srsd_pkg::MP_W-1:0];
        srsd_pkg::REG_STOP_THRESHOLD: th_q <= pwdata[srsd_pkg::TH_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_eff    = (mp_q == '0) ? srsd_pkg::mp_t'(1) : mp_q;
  assign two_m    = srsd_pkg::cmp_t'({m_eff, 1'b0});
  assign wp_inc   = (wp_q == srsd_pkg::addr_t'(srsd_pkg::WINDOW - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc   = (rp_q == srsd_pkg::addr_t'(srsd_pkg::WINDOW - 1)) ? '0 : rp_q + 1'b1;
  assign fill_inc = (fill_q == srsd_pkg::cnt_t'(srsd_pkg::WINDOW)) ? fill_q : fill_q + 1'b1;
  assign len_ok   = srsd_pkg::cmp_t'(fill_inc) >= two_m;
  assign wrap_sum = srsd_pkg::cmp_t'(wp_inc) + srsd_pkg::cmp_t'(srsd_pkg::WINDOW)
                    - srsd_pkg::cmp_t'(fill_inc);
  assign oldest   = (srsd_pkg::cmp_t'(wp_inc) >= srsd_pkg::cmp_t'(fill_inc)) ?
                    srsd_pkg::addr_t'(srsd_pkg::cmp_t'(wp_inc) - srsd_pkg::cmp_t'(fill_inc)) :
                    srsd_pkg::addr_t'(wrap_sum);
  assign issuing  = (state_q == srsd_pkg::ST_SCAN) && (issue_q != scan_len_q) && !match_q;

  // Lane i compares the stored byte against the i-th newest byte; bit i of the
  // match vector marks a pattern prefix of length m - i ending at this byte.
  always_comb begin
    for (int i = 0; i < srsd_pkg::LANES; i++) begin
      lane_eq[i]    = (hist_q[i] == rd_data);
      lane_mask[i]  = (srsd_pkg::mp_t'(i) < m_eff);
      lane_first[i] = (srsd_pkg::mp_t'(i) == m_eff - 1'b1);
    end
    dvec_next = ((dvec_q >> 1) | lane_first) & lane_eq & lane_mask;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    issue_d     = issue_q;
    scan_len_d  = scan_len_q;
    rd_vld_d    = 1'b0;
    dvec_d      = dvec_q;
    match_d     = match_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      srsd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func_i == srsd_pkg::FUNC_RESTART) begin
            fill_d = '0;
            run_d  = '0;
          end else begin
            ram_we = 1'b1;
            wp_d   = wp_inc;
            fill_d = fill_inc;
            if (in_piece_end_i) begin
              state_d    = srsd_pkg::ST_SCAN;
              rp_d       = oldest;
              issue_d    = '0;
              scan_len_d = len_ok ? fill_inc - 1'b1 : '0;
              dvec_d     = '0;
              match_d    = 1'b0;
            end
          end
        end
      end
      srsd_pkg::ST_SCAN: begin
        if (issuing) begin
          ram_re   = 1'b1;
          rp_d     = rp_inc;
          issue_d  = issue_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          dvec_d  = dvec_next;
          match_d = match_q | dvec_next[0];
        end
        if (!issuing && !rd_vld_q) begin
          state_d = srsd_pkg::ST_DONE;
        end
      end
      srsd_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (match_q) begin
            run_d = (run_q == srsd_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
          end else begin
            run_d = '0;
          end
          state_d = srsd_pkg::ST_IDLE;
        end
      end
      default: state_d = srsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srsd_pkg::ST_IDLE;
      fill_q      <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      issue_q     <= '0;
      scan_len_q  <= '0;
      rd_vld_q    <= 1'b0;
      dvec_q      <= '0;
      match_q     <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      issue_q     <= issue_d;
      scan_len_q  <= scan_len_d;
      rd_vld_q    <= rd_vld_d;
      dvec_q      <= dvec_d;
      match_q     <= match_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rep_q  <= match_q;
      out_stop_q <= match_q && (run_d > th_q);
      out_run_q  <= run_d;
    end
    if (ram_we) begin
      hist_q[0] <= in_text_byte_i;
      for (int i = 1; i < srsd_pkg::LANES; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  srsd_ram #(
    .WIDTH (srsd_pkg::BYTE_W),
    .DEPTH (srsd_pkg::WINDOW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_text_byte_i),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (rd_data)
  );

  assign out_valid_o      = out_valid_q;
  assign out_repetitive_o = out_rep_q;
  assign out_stop_o       = out_stop_q;
  assign out_run_length_o = out_run_q;

  `SRSD_ASSERT(a_fill_bound, fill_q <= srsd_pkg::cnt_t'(srsd_pkg::WINDOW), "fill count beyond window")
  `SRSD_ASSERT(a_rd_in_scan, rd_vld_q |-> state_q == srsd_pkg::ST_SCAN, "read data outside sweep")
  `SRSD_ASSERT(a_match_len, (state_q == srsd_pkg::ST_SCAN && match_q) |-> srsd_pkg::cmp_t'(fill_q) >= two_m, "match on short window")
  `SRSD_ASSERT(a_stop_rep, (out_valid_o && out_stop_o) |-> (out_repetitive_o && out_run_length_o != '0), "stop without run")
  `SRSD_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q) == srsd_pkg::ST_DONE, "result beat not from done state")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of suffix_repetition_stop_detector_top.
// Depends on srsd_pkg; predicts checks of untyped rows from its own text window.
module testbench;

  localparam int SETTLE_CYCLES  = srsd_pkg::WINDOW + 14;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 8;

  typedef struct packed {
    logic           rep;
    logic           stop;
    srsd_pkg::run_t run;
  } verdict_t;

  typedef struct {
    logic            func;
    srsd_pkg::byte_t data;
    logic            pe;
    bit              typed;
    verdict_t        v;
  } text_row_t;

  localparam verdict_t QUIET_VERDICT = '0;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          in_func_i = 1'b0;
  logic [7:0]                    in_text_byte_i = '0;
  logic                          in_piece_end_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          out_repetitive_o;
  logic                          out_stop_o;
  logic [3:0]                    out_run_length_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [srsd_pkg::PADDR_W-1:0]  paddr = '0;
  logic [srsd_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [srsd_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  logic     row_typed = 1'b0;
  verdict_t row_verdict = '0;

  srsd_pkg::byte_t text_win [srsd_pkg::WINDOW];
  int              fill_level;
  srsd_pkg::run_t  run_len;
  srsd_pkg::mp_t   pat_min;
  srsd_pkg::th_t   stop_th;
  verdict_t        pending_verdicts [$];
  text_row_t       rows [$];
  int              errors = 0;
  int              idle_cycles = 0;
  int              stall_left = 0;
  bit              zero_gap = 1'b0;

  suffix_repetition_stop_detector_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_func_i        (in_func_i),
    .in_text_byte_i   (in_text_byte_i),
    .in_piece_end_i   (in_piece_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_repetitive_o (out_repetitive_o),
    .out_stop_o       (out_stop_o),
    .out_run_length_o (out_run_length_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void add_row(input logic func, input srsd_pkg::byte_t data,
                                  input logic pe, input bit typed, input verdict_t v);
    text_row_t r;
    r.func  = func;
    r.data  = data;
    r.pe    = pe;
    r.typed = typed;
    r.v     = v;
    rows.insert(rows.size(), r);
  endfunction

  function automatic bit advance_window(input logic func, input srsd_pkg::byte_t data,
                                        input logic pe, output verdict_t v);
    int m;
    int start;
    bit hit;
    bit same;
    v = '0;
    if (func == srsd_pkg::FUNC_RESTART) begin
      fill_level = 0;
      run_len = '0;
      return 1'b0;
    end
    if (fill_level >= srsd_pkg::WINDOW) begin
      for (int i = 0; i < srsd_pkg::WINDOW - 1; i++) text_win[i] = text_win[i+1];
      fill_level = srsd_pkg::WINDOW - 1;
    end
    text_win[fill_level] = data;
    fill_level++;
    if (!pe) return 1'b0;
    m = (pat_min == '0) ? 1 : int'(pat_min);
    hit = 1'b0;
    if (fill_level >= 2 * m) begin
      start = fill_level - m;
      for (int p = 0; p < start && !hit; p++) begin
        same = 1'b1;
        for (int k = 0; k < m; k++) begin
          if (text_win[p+k] != text_win[start+k]) same = 1'b0;
        end
        hit = same;
      end
    end
    if (hit) begin
      if (run_len != srsd_pkg::RUN_MAX) run_len++;
    end else begin
      run_len = '0;
    end
    v.rep  = hit;
    v.stop = hit && (run_len > stop_th);
    v.run  = run_len;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    verdict_t predicted;
    bit active;
    active = 1'b0;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        active = 1'b1;
        got = '{rep: out_repetitive_o, stop: out_stop_o, run: out_run_length_o};
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result beat with nothing expected", 32'(got), 32'(0));
        end else begin
          want = pending_verdicts[0];
          pending_verdicts.delete(0);
          if (got.rep !== want.rep) report_mismatch("repetitive", 32'(got.rep), 32'(want.rep));
          if (got.stop !== want.stop) report_mismatch("stop", 32'(got.stop), 32'(want.stop));
          if (got.run !== want.run) report_mismatch("run_length", 32'(got.run), 32'(want.run));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        active = 1'b1;
        if (advance_window(in_func_i, in_text_byte_i, in_piece_end_i, predicted)) begin
          pending_verdicts.insert(pending_verdicts.size(),
                                  row_typed ? row_verdict : predicted);
        end
      end
      if (psel && penable && pready) active = 1'b1;
      if (active) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      stall_left = zero_gap ? 0 : $urandom_range(0, 15);
    end else if (out_valid_o === 1'b1 && stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic send_beat(input logic func, input srsd_pkg::byte_t data, input logic pe,
                           input bit typed, input verdict_t tv);
    int gap;
    gap = zero_gap ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_func_i      <= func;
    in_text_byte_i <= data;
    in_piece_end_i <= pe;
    row_typed      <= typed;
    row_verdict    <= tv;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input srsd_pkg::reg_idx_t idx,
                           input logic [srsd_pkg::PDATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= srsd_pkg::PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      srsd_pkg::REG_MIN_PATTERN:    pat_min = val[srsd_pkg::MP_W-1:0];
      srsd_pkg::REG_STOP_THRESHOLD: stop_th = val[srsd_pkg::TH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_check(input srsd_pkg::reg_idx_t idx,
                           input logic [srsd_pkg::PDATA_W-1:0] want);
    logic [srsd_pkg::PDATA_W-1:0] data;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= srsd_pkg::PADDR_W'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data !== want) report_mismatch("register readback", data, want);
  endtask

  task automatic random_text(input int count);
    int              sent;
    int              mode;
    int              plen;
    int              reps;
    bit              narrow;
    srsd_pkg::byte_t pat [16];
    srsd_pkg::byte_t b;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(0, 99);
      zero_gap = ($urandom_range(0, 4) == 0);
      if (mode < 5) begin
        send_beat(srsd_pkg::FUNC_RESTART, srsd_pkg::byte_t'($urandom),
                  logic'($urandom_range(0, 1)), 1'b0, QUIET_VERDICT);
        sent++;
      end else if (mode < 25) begin
        reps = $urandom_range(1, 20);
        for (int k = 0; k < reps; k++) begin
          send_beat(srsd_pkg::FUNC_APPEND, srsd_pkg::byte_t'($urandom),
                    ($urandom_range(0, 2) == 0), 1'b0, QUIET_VERDICT);
          sent++;
        end
      end else begin
        plen = $urandom_range(1, 13);
        narrow = ($urandom_range(0, 1) == 0);
        for (int k = 0; k < plen; k++) begin
          pat[k] = narrow ? srsd_pkg::byte_t'($urandom_range(0, 3))
                          : srsd_pkg::byte_t'($urandom);
        end
        reps = $urandom_range(2, 60 / plen + 2);
        for (int k = 0; k < plen * reps; k++) begin
          b = pat[k % plen];
          if ($urandom_range(0, 49) == 0) b = srsd_pkg::byte_t'($urandom);
          send_beat(srsd_pkg::FUNC_APPEND, b, ($urandom_range(0, 2) == 0), 1'b0,
                    QUIET_VERDICT);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int              mp_set [PHASES] = '{1, 25, 0, 31, 2, 12, 5, 3};
    int              th_set [PHASES] = '{0, 14, 15, 0, 1, 7, 2, 3};
    srsd_pkg::byte_t pat5 [5] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80};
    fill_level = 0;
    run_len    = '0;
    pat_min    = srsd_pkg::MIN_PATTERN_RST;
    stop_th    = srsd_pkg::STOP_THRESHOLD_RST;
    for (int i = 0; i < srsd_pkg::WINDOW; i++) text_win[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(srsd_pkg::FUNC_APPEND, 8'h00, 1'b1, 1'b1, QUIET_VERDICT);
    add_row(srsd_pkg::FUNC_APPEND, 8'hFF, 1'b1, 1'b1, QUIET_VERDICT);
    add_row(srsd_pkg::FUNC_RESTART, 8'hFF, 1'b1, 1'b0, QUIET_VERDICT);
    for (int k = 0; k < 5; k++) add_row(srsd_pkg::FUNC_APPEND, pat5[k], 1'b0, 1'b0, QUIET_VERDICT);
    for (int k = 0; k < 5; k++) begin
      add_row(srsd_pkg::FUNC_APPEND, pat5[k], logic'(k == 4), 1'b0, QUIET_VERDICT);
    end
    for (int k = 0; k < 5; k++) add_row(srsd_pkg::FUNC_APPEND, pat5[k], 1'b1, 1'b0, QUIET_VERDICT);
    add_row(srsd_pkg::FUNC_APPEND, 8'h12, 1'b1, 1'b0, QUIET_VERDICT);
    add_row(srsd_pkg::FUNC_RESTART, 8'h00, 1'b1, 1'b0, QUIET_VERDICT);
    add_row(srsd_pkg::FUNC_APPEND, 8'h7F, 1'b1, 1'b1, QUIET_VERDICT);
    apb_check(srsd_pkg::REG_MIN_PATTERN, srsd_pkg::PDATA_W'(srsd_pkg::MIN_PATTERN_RST));
    apb_check(srsd_pkg::REG_STOP_THRESHOLD, srsd_pkg::PDATA_W'(srsd_pkg::STOP_THRESHOLD_RST));
    foreach (rows[i]) send_beat(rows[i].func, rows[i].data, rows[i].pe, rows[i].typed, rows[i].v);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      apb_write(srsd_pkg::REG_MIN_PATTERN, srsd_pkg::PDATA_W'(mp_set[ph]));
      if (ph != 3) apb_write(srsd_pkg::REG_STOP_THRESHOLD, srsd_pkg::PDATA_W'(th_set[ph]));
      apb_check(srsd_pkg::REG_MIN_PATTERN, srsd_pkg::PDATA_W'(pat_min));
      apb_check(srsd_pkg::REG_STOP_THRESHOLD, srsd_pkg::PDATA_W'(stop_th));
      random_text(150);
      zero_gap = 1'b0;
      settle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
